// File: sv/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SNOI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define SNOI_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: sv/snoi_pkg.sv
// Package for the sorted newline offset index: sizes, codes and shared types.
// No dependencies.
package snoi_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int POSITION_BITS = 32;

    localparam int POS_W      = POSITION_BITS;
    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
    localparam int WIDE_W     = (POSITION_BITS > 32) ? POSITION_BITS : 32;
    localparam int LINE_CMP_W = (CNT_W > 16) ? CNT_W : 16;

    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [WIDE_W-1:0]     wide_t;
    typedef logic [LINE_CMP_W-1:0] line_cmp_t;

    localparam pos_t POS_MAX = '1;

    // Item kinds
    localparam logic [2:0] K_REBUILD  = 3'd0;
    localparam logic [2:0] K_SCAN     = 3'd1;
    localparam logic [2:0] K_INS_BASE = 3'd2;
    localparam logic [2:0] K_INS_NL   = 3'd3;
    localparam logic [2:0] K_ERASE    = 3'd4;
    localparam logic [2:0] K_LOC_OFF  = 3'd5;
    localparam logic [2:0] K_LOC_LINE = 3'd6;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // Operation carried out by one pass around the ring
    typedef enum logic [2:0] {
        OP_INSERT,
        OP_SHIFT,
        OP_ERASE,
        OP_LOCOFF,
        OP_LOCLINE
    } pass_op_t;

    typedef struct packed {
        pass_op_t  op;
        pos_t      value;
        pos_t      pos;
        pos_t      amount;
        cnt_t      count;
        line_cmp_t line_sel;
    } pass_cmd_t;

    typedef struct packed {
        logic sat;
        logic erased;
        cnt_t lo;
        pos_t prev;
        pos_t line_val;
    } pass_stat_t;

endpackage

// File: sv/snoi_cell.sv
// One storage cell of the offset ring: holds one table entry.
// Depends on snoi_pkg.
module snoi_cell
    import snoi_pkg::*;
(
    input  logic clk,
    input  logic shift,
    input  pos_t d,
    output pos_t q
);

    pos_t val_reg;

    // Take the neighbor's entry while the ring turns
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            val_reg <= d;
        end
    end

    assign q = val_reg;

endmodule

// File: sv/snoi_proc.sv
// Stream processor at the head of the offset ring: rewrites, inserts, drops
// or inspects one entry per cycle during a pass. Depends on snoi_pkg.
module snoi_proc
    import snoi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       clear,
    input  logic       active,
    input  idx_t       step,
    input  pass_cmd_t  cmd,
    input  pos_t       tail,
    input  pos_t       tail_next,
    output pos_t       head,
    output pass_stat_t stat
);

    logic hold_reg, hold_next;
    logic skip_reg, skip_next;
    logic found_reg, found_next;
    logic sat_reg, sat_next;
    logic erased_reg, erased_next;
    cnt_t lo_reg, lo_next;
    pos_t hold_val_reg, hold_val_next;
    pos_t prev_reg, prev_next;
    pos_t line_val_reg, line_val_next;

    logic           in_table;
    logic [POS_W:0] shift_sum;
    pos_t           diff;

    assign in_table  = cnt_t'(step) < cmd.count;
    assign shift_sum = {1'b0, tail} + {1'b0, cmd.amount};
    assign diff      = tail - cmd.pos;

    // Decide the entry written into the ring this cycle
    always_comb
    begin
        head          = tail;
        hold_next     = hold_reg;
        skip_next     = skip_reg;
        found_next    = found_reg;
        sat_next      = sat_reg;
        erased_next   = erased_reg;
        lo_next       = lo_reg;
        hold_val_next = hold_val_reg;
        prev_next     = prev_reg;
        line_val_next = line_val_reg;
        unique case (cmd.op)
            OP_INSERT:
            begin
                if (hold_reg)
                begin
                    head          = hold_val_reg;
                    hold_val_next = tail;
                end
                else if (!in_table || tail >= cmd.value)
                begin
                    head          = cmd.value;
                    hold_next     = 1'b1;
                    hold_val_next = tail;
                end
            end
            OP_SHIFT:
            begin
                if (in_table && tail >= cmd.pos)
                begin
                    if (shift_sum[POS_W])
                    begin
                        head     = POS_MAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        head = shift_sum[POS_W-1:0];
                    end
                end
            end
            OP_ERASE:
            begin
                if (skip_reg)
                begin
                    head = tail_next;
                end
                else if (found_reg)
                begin
                    if (in_table)
                    begin
                        head = tail - cmd.amount;
                    end
                end
                else if (in_table && tail >= cmd.pos)
                begin
                    if (diff < cmd.amount)
                    begin
                        head        = tail_next;
                        skip_next   = 1'b1;
                        erased_next = 1'b1;
                    end
                    else
                    begin
                        head       = tail - cmd.amount;
                        found_next = 1'b1;
                    end
                end
            end
            OP_LOCOFF:
            begin
                if (!found_reg)
                begin
                    if (!in_table || tail >= cmd.pos)
                    begin
                        found_next = 1'b1;
                        lo_next    = cnt_t'(step);
                    end
                    else
                    begin
                        prev_next = tail;
                    end
                end
            end
            OP_LOCLINE:
            begin
                if (line_cmp_t'(step) == cmd.line_sel)
                begin
                    line_val_next = tail;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Clear pass state before a pass, advance it while the ring turns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= 1'b0;
            skip_reg   <= 1'b0;
            found_reg  <= 1'b0;
            sat_reg    <= 1'b0;
            erased_reg <= 1'b0;
            lo_reg     <= '0;
        end
        else if (clear)
        begin
            hold_reg   <= 1'b0;
            skip_reg   <= 1'b0;
            found_reg  <= 1'b0;
            sat_reg    <= 1'b0;
            erased_reg <= 1'b0;
            lo_reg     <= cmd.count;
        end
        else if (active)
        begin
            hold_reg   <= hold_next;
            skip_reg   <= skip_next;
            found_reg  <= found_next;
            sat_reg    <= sat_next;
            erased_reg <= erased_next;
            lo_reg     <= lo_next;
        end
    end

    // Payload of the pass
    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            prev_reg <= '0;
        end
        else if (active)
        begin
            hold_val_reg <= hold_val_next;
            prev_reg     <= prev_next;
            line_val_reg <= line_val_next;
        end
    end

    assign stat.sat      = sat_reg;
    assign stat.erased   = erased_reg;
    assign stat.lo       = lo_reg;
    assign stat.prev     = prev_reg;
    assign stat.line_val = line_val_reg;

endmodule

// File: sv/sorted_newline_offset_index.sv
// Top level of the sorted newline offset index: control, ring of cells,
// result register. Depends on snoi_pkg, snoi_cell and snoi_proc.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one item: kind and its fields.
//   Output channel (out_valid / out_stall) gives exactly one result per item.
//   The table lives in a ring of TABLE_DEPTH cells; one pass turns the ring
//   once through a processor at its head.
//   Rebuild start, plain scan bytes, dropped inserts, unused kinds and line
//   queries on line 0 or an empty table give their result without a pass.
//   Scan newlines, insert start, insert newline and both queries run one
//   pass. An erase runs one pass per entry that it removes, and one more.
//   One item is worked on at a time; in_stall is high from acceptance until
//   the result is moved into the output register, which then frees the input.
//   A result waits in the output register while out_stall is high, and the
//   next item may be accepted and worked on meanwhile.
//   Reset clears the count, scan position and insert point; table cells hold
//   no reset value and are only read below the count.
module sorted_newline_offset_index
    import snoi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] position,
    input  logic [31:0] amount,
    input  logic [31:0] rel_offset,
    input  logic [15:0] line_number,
    input  logic [31:0] column,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] line_out,
    output logic [31:0] column_out,
    output logic [31:0] offset_out,
    output logic [10:0] newline_total,
    output logic [1:0]  status
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_PASS = 5'b00100,
        S_END  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    cnt_t       cnt_reg, cnt_next;
    pos_t       scan_reg, scan_next;
    pos_t       base_reg, base_next;
    idx_t       step_reg, step_next;
    logic       item_sat_reg, item_sat_next;
    pass_cmd_t  cmd_reg, cmd_next;
    pos_t       col_reg, col_next;
    logic [10:0] p_line_reg, p_line_next;
    logic [31:0] p_col_reg, p_col_next;
    logic [31:0] p_off_reg, p_off_next;
    logic [1:0]  p_status_reg, p_status_next;
    logic        out_valid_reg;
    logic [10:0] line_out_reg;
    logic [31:0] column_out_reg;
    logic [31:0] offset_out_reg;
    logic [10:0] total_reg;
    logic [1:0]  status_reg;

    pass_stat_t stat;
    pos_t       ring [TABLE_DEPTH];
    pos_t       head;
    logic       accept;
    logic       load_out;
    logic       full;

    pos_t           pos_in, amt_in, rel_in, col_in;
    logic [POS_W:0] scan_sum, nl_sum;
    logic [POS_W+1:0] off_sum;
    line_cmp_t      line_w, cnt_w, line_lim;
    wide_t          col_w;

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;
    assign load_out = (state_reg == S_DONE) && !(out_valid_reg && out_stall);
    assign full     = cnt_reg >= cnt_t'(TABLE_DEPTH);

    assign pos_in   = pos_t'(position);
    assign amt_in   = pos_t'(amount);
    assign rel_in   = pos_t'(rel_offset);
    assign col_in   = pos_t'(column);
    assign scan_sum = {1'b0, scan_reg} + (POS_W+1)'(1);
    assign nl_sum   = {1'b0, base_reg} + {1'b0, rel_in};
    assign line_w   = line_cmp_t'(line_number);
    assign cnt_w    = line_cmp_t'(cnt_reg);
    assign line_lim = (line_w > cnt_w) ? cnt_w : line_w;
    assign off_sum  = (POS_W+2)'(stat.line_val) + (POS_W+2)'(col_reg) + (POS_W+2)'(1);
    assign col_w    = (stat.lo == '0) ? wide_t'(cmd_reg.pos)
                    : wide_t'(cmd_reg.pos) - (wide_t'(stat.prev) + wide_t'(1));

    // Sequence items through passes of the ring
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        scan_next     = scan_reg;
        base_next     = base_reg;
        step_next     = step_reg;
        item_sat_next = item_sat_reg;
        cmd_next      = cmd_reg;
        col_next      = col_reg;
        p_line_next   = p_line_reg;
        p_col_next    = p_col_reg;
        p_off_next    = p_off_reg;
        p_status_next = p_status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    p_line_next   = '0;
                    p_col_next    = '0;
                    p_off_next    = '0;
                    p_status_next = ST_OK;
                    item_sat_next = 1'b0;
                    cmd_next.pos      = pos_in;
                    cmd_next.amount   = amt_in;
                    cmd_next.count    = cnt_reg;
                    cmd_next.line_sel = line_lim - line_cmp_t'(1);
                    col_next          = col_in;
                    state_next        = S_DONE;
                    unique case (kind)
                        K_REBUILD:
                        begin
                            cnt_next  = '0;
                            scan_next = '0;
                        end
                        K_SCAN:
                        begin
                            scan_next     = scan_sum[POS_W] ? POS_MAX : scan_sum[POS_W-1:0];
                            item_sat_next = scan_sum[POS_W];
                            p_status_next = scan_sum[POS_W] ? ST_SAT : ST_OK;
                            if (data_byte == NEWLINE_BYTE)
                            begin
                                if (full)
                                begin
                                    p_status_next = ST_FULL;
                                end
                                else
                                begin
                                    cmd_next.op    = OP_INSERT;
                                    cmd_next.value = scan_reg;
                                    state_next     = S_PREP;
                                end
                            end
                        end
                        K_INS_BASE:
                        begin
                            base_next   = pos_in;
                            cmd_next.op = OP_SHIFT;
                            state_next  = S_PREP;
                        end
                        K_INS_NL:
                        begin
                            item_sat_next = nl_sum[POS_W];
                            if (full)
                            begin
                                p_status_next = ST_FULL;
                            end
                            else
                            begin
                                cmd_next.op    = OP_INSERT;
                                cmd_next.value = nl_sum[POS_W] ? POS_MAX : nl_sum[POS_W-1:0];
                                state_next     = S_PREP;
                            end
                        end
                        K_ERASE:
                        begin
                            cmd_next.op = OP_ERASE;
                            state_next  = S_PREP;
                        end
                        K_LOC_OFF:
                        begin
                            cmd_next.op = OP_LOCOFF;
                            state_next  = S_PREP;
                        end
                        K_LOC_LINE:
                        begin
                            if (line_number == '0 || cnt_reg == '0)
                            begin
                                p_off_next = 32'(col_in);
                            end
                            else
                            begin
                                cmd_next.op = OP_LOCLINE;
                                state_next  = S_PREP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PREP:
            begin
                step_next  = '0;
                state_next = S_PASS;
            end
            S_PASS:
            begin
                step_next = step_reg + idx_t'(1);
                if (step_reg == idx_t'(TABLE_DEPTH - 1))
                begin
                    state_next = S_END;
                end
            end
            S_END:
            begin
                state_next = S_DONE;
                unique case (cmd_reg.op)
                    OP_INSERT:
                    begin
                        cnt_next      = cnt_reg + cnt_t'(1);
                        p_status_next = item_sat_reg ? ST_SAT : ST_OK;
                    end
                    OP_SHIFT:
                    begin
                        p_status_next = stat.sat ? ST_SAT : ST_OK;
                    end
                    OP_ERASE:
                    begin
                        if (stat.erased)
                        begin
                            cnt_next       = cnt_reg - cnt_t'(1);
                            cmd_next.count = cnt_reg - cnt_t'(1);
                            state_next     = S_PREP;
                        end
                    end
                    OP_LOCOFF:
                    begin
                        p_line_next = 11'(stat.lo);
                        p_col_next  = 32'(col_w);
                    end
                    OP_LOCLINE:
                    begin
                        if (off_sum > (POS_W+2)'(POS_MAX))
                        begin
                            p_off_next    = 32'(POS_MAX);
                            p_status_next = ST_SAT;
                        end
                        else
                        begin
                            p_off_next = 32'(off_sum);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            scan_reg      <= '0;
            base_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            scan_reg  <= scan_next;
            base_reg  <= base_next;
            step_reg  <= step_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold item payload and the result register
    always_ff @(posedge clk)
    begin
        item_sat_reg <= item_sat_next;
        cmd_reg      <= cmd_next;
        col_reg      <= col_next;
        p_line_reg   <= p_line_next;
        p_col_reg    <= p_col_next;
        p_off_reg    <= p_off_next;
        p_status_reg <= p_status_next;
        if (load_out)
        begin
            line_out_reg   <= p_line_reg;
            column_out_reg <= p_col_reg;
            offset_out_reg <= p_off_reg;
            total_reg      <= 11'(cnt_reg);
            status_reg     <= p_status_reg;
        end
    end

    // Ring of cells: entry j leaves the tail at step j of a pass
    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_ring
        if (k == 0)
        begin : g_head
            snoi_cell u_cell (
                .clk   (clk),
                .shift (state_reg == S_PASS),
                .d     (head),
                .q     (ring[k])
            );
        end
        else
        begin : g_body
            snoi_cell u_cell (
                .clk   (clk),
                .shift (state_reg == S_PASS),
                .d     (ring[k-1]),
                .q     (ring[k])
            );
        end
    end

    snoi_proc u_proc (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (state_reg == S_PREP),
        .active    (state_reg == S_PASS),
        .step      (step_reg),
        .cmd       (cmd_reg),
        .tail      (ring[TABLE_DEPTH-1]),
        .tail_next (ring[TABLE_DEPTH-2]),
        .head      (head),
        .stat      (stat)
    );

    assign out_valid     = out_valid_reg;
    assign line_out      = line_out_reg;
    assign column_out    = column_out_reg;
    assign offset_out    = offset_out_reg;
    assign newline_total = total_reg;
    assign status        = status_reg;

endmodule

// File: sv/snoi_checker.sv
// Port-level checker for the sorted newline offset index, bound to the top.
// Depends on snoi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module snoi_checker
    import snoi_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [10:0] line_out,
    input logic [31:0] column_out,
    input logic [31:0] offset_out,
    input logic [10:0] newline_total,
    input logic [1:0]  status
);

    // One item at a time: an accepted item blocks the input
    `SNOI_ASSERT(a_busy_after_accept, clk, rst_n,
                 (in_valid && !in_stall) |=> in_stall, "input not blocked after accept")

    // Status takes only its defined codes
    `SNOI_NEVER(a_status_code, clk, rst_n, out_valid && status == 2'd3, "undefined status code")

    // A dropped newline only happens on a full table
    `SNOI_ASSERT(a_full_total, clk, rst_n,
                 (out_valid && status == ST_FULL) |-> (newline_total == 11'(TABLE_DEPTH)),
                 "full status with room left")

    // A stalled result holds
    `SNOI_ASSERT(a_out_hold, clk, rst_n,
                 (out_valid && out_stall) |=> (out_valid && $stable(line_out) && $stable(column_out) && $stable(offset_out) && $stable(newline_total) && $stable(status)),
                 "stalled result changed")

endmodule

bind sorted_newline_offset_index snoi_checker u_snoi_checker (.*);
